// ===== src/jse_pkg.sv =====
package jse_pkg;

  localparam int unsigned QueueDepthDefault = 4;

  localparam logic [7:0] CharQuote  = 8'h22;
  localparam logic [7:0] CharBslash = 8'h5c;
  localparam logic [7:0] CharLowerU = 8'h75;
  localparam logic [7:0] CharLowerN = 8'h6e;
  localparam logic [7:0] CharLowerT = 8'h74;
  localparam logic [7:0] CharLowerR = 8'h72;
  localparam logic [7:0] CharNul    = 8'h00;

  localparam logic [20:0] ValBslash = 21'h00005c;
  localparam logic [20:0] ValQuote  = 21'h000022;
  localparam logic [20:0] ValLf     = 21'h00000a;
  localparam logic [20:0] ValTab    = 21'h000009;
  localparam logic [20:0] ValCr     = 21'h00000d;
  localparam logic [20:0] ValRawLo  = 21'h000020;
  localparam logic [20:0] ValRawHi  = 21'h00007f;
  localparam logic [20:0] Val4Max   = 21'h00ffff;
  localparam logic [20:0] Val5Max   = 21'h0fffff;

  localparam logic CmdByte = 1'b0;
  localparam logic CmdEnd  = 1'b1;

  typedef struct packed {
    logic       command;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       last;
    logic       error;
  } out_item_t;

  // what the back end has to emit for one accepted item
  typedef enum logic [2:0] {
    KIND_NONE  = 3'd0,
    KIND_RAW   = 3'd1,
    KIND_ESC   = 3'd2,
    KIND_HEX   = 3'd3,
    KIND_CLOSE = 3'd4,
    KIND_ERR   = 3'd5
  } kind_e;

  typedef struct packed {
    logic        open_quote;
    kind_e       kind;
    logic [7:0]  chr;
    logic [2:0]  nd;
    logic [20:0] value;
  } action_t;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] chr;
    logic [2:0] nd;
  } val_class_t;

  function automatic val_class_t classify(logic [20:0] v);
    val_class_t c;
    c.kind = KIND_HEX;
    c.chr  = v[7:0];
    c.nd   = 3'd4;
    if (v > Val4Max) c.nd = 3'd5;
    if (v > Val5Max) c.nd = 3'd6;
    if (v == ValBslash) begin
      c.kind = KIND_ESC;
      c.chr  = CharBslash;
    end else if (v == ValQuote) begin
      c.kind = KIND_ESC;
      c.chr  = CharQuote;
    end else if (v == ValLf) begin
      c.kind = KIND_ESC;
      c.chr  = CharLowerN;
    end else if (v == ValTab) begin
      c.kind = KIND_ESC;
      c.chr  = CharLowerT;
    end else if (v == ValCr) begin
      c.kind = KIND_ESC;
      c.chr  = CharLowerR;
    end else if (v >= ValRawLo && v <= ValRawHi) begin
      c.kind = KIND_RAW;
    end
    return c;
  endfunction

  function automatic logic [7:0] hex_char(logic [3:0] n);
    logic [7:0] r;
    if (n < 4'd10) r = 8'h30 + {4'h0, n};
    else r = 8'h57 + {4'h0, n};
    return r;
  endfunction

endpackage

// ===== src/utf8_json_string_escaper_core.sv =====
// Turns a byte stream into a quoted JSON string literal, one output character per transfer.
// UTF-8 is decoded in the front end, which takes one byte per cycle and stalls only when the
// action queue (QueueDepth entries) is full; the back end sequencer sends one character per
// cycle through a registered output while not stalled. A byte that maps to one character thus
// sustains one byte per cycle; one mapping to k characters (2 for short escapes, up to 8 for \u
// forms, plus one for the opening quote) holds the output until all k are sent. Lead bytes of
// multibyte sequences give no transfer but an opening quote, bytes dropped after an error none.
// Actions pass through the queue, then the output register. Malformed input gives one error
// transfer with last set and out_char zero, then bytes are dropped until the end command.
module utf8_json_string_escaper_core #(
  parameter int unsigned QueueDepth = jse_pkg::QueueDepthDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  jse_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output jse_pkg::out_item_t res_item_o
);

  logic             push, full, pop, head_valid;
  jse_pkg::action_t push_data, head_data;

  jse_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .q_full_i    (full),
    .push_o      (push),
    .push_data_o (push_data)
  );

  jse_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_data_i  (push_data),
    .full_o       (full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_data_o  (head_data)
  );

  jse_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_data_i  (head_data),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .res_item_o   (res_item_o)
  );

endmodule

// ===== src/jse_front.sv =====
module jse_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  jse_pkg::in_item_t  in_data_i,
  input  logic               q_full_i,
  output logic               push_o,
  output jse_pkg::action_t   push_data_o
);

  typedef enum logic [2:0] {
    PH_IDLE    = 3'b001,
    PH_STRING  = 3'b010,
    PH_DISCARD = 3'b100
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [1:0]  pend_q, pend_d;
  logic [20:0] cp_q, cp_d;
  logic        accept;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;

  always_comb begin
    jse_pkg::action_t   act;
    jse_pkg::val_class_t vc;
    logic [20:0]        cp_n;
    logic [20:0]        val;
    logic               has_val;
    logic [7:0]         b;
    b          = in_data_i.data_byte;
    act        = '0;
    act.kind   = jse_pkg::KIND_NONE;
    val        = '0;
    has_val    = 1'b0;
    cp_n       = {cp_q[14:0], b[5:0]};
    phase_d    = phase_q;
    pend_d     = pend_q;
    cp_d       = cp_q;

    if (in_data_i.command == jse_pkg::CmdEnd) begin
      if (phase_q != PH_DISCARD) begin
        act.open_quote = (phase_q == PH_IDLE);
        act.kind = (pend_q != 2'd0) ? jse_pkg::KIND_ERR : jse_pkg::KIND_CLOSE;
      end
      phase_d = PH_IDLE;
      pend_d  = 2'd0;
      cp_d    = '0;
    end else if (phase_q != PH_DISCARD) begin
      if (phase_q == PH_IDLE) begin
        act.open_quote = 1'b1;
        phase_d = PH_STRING;
      end
      if (pend_q != 2'd0) begin
        if (b[7:6] != 2'b10) begin
          act.kind = jse_pkg::KIND_ERR;
          phase_d  = PH_DISCARD;
          pend_d   = 2'd0;
          cp_d     = '0;
        end else begin
          pend_d = pend_q - 2'd1;
          if (pend_q == 2'd1) begin
            has_val = 1'b1;
            val     = cp_n;
            cp_d    = '0;
          end else begin
            cp_d = cp_n;
          end
        end
      end else if (!b[7]) begin
        has_val = 1'b1;
        val     = {13'h0, b};
      end else if (!b[6]) begin
        // stray continuation byte taken as its low seven bits
        has_val = 1'b1;
        val     = {14'h0, b[6:0]};
      end else if (!b[5]) begin
        cp_d   = {16'h0, b[4:0]};
        pend_d = 2'd1;
      end else if (!b[4]) begin
        cp_d   = {17'h0, b[3:0]};
        pend_d = 2'd2;
      end else if (!b[3]) begin
        cp_d   = {18'h0, b[2:0]};
        pend_d = 2'd3;
      end else begin
        act.kind = jse_pkg::KIND_ERR;
        phase_d  = PH_DISCARD;
        pend_d   = 2'd0;
        cp_d     = '0;
      end
    end

    if (has_val) begin
      vc        = jse_pkg::classify(val);
      act.kind  = vc.kind;
      act.chr   = vc.chr;
      act.nd    = vc.nd;
      act.value = val;
    end else begin
      vc = '0;
    end

    push_data_o = act;
    push_o = accept && (act.open_quote || act.kind != jse_pkg::KIND_NONE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      pend_q  <= 2'd0;
      cp_q    <= '0;
    end else if (accept) begin
      phase_q <= phase_d;
      pend_q  <= pend_d;
      cp_q    <= cp_d;
    end
  end

endmodule

// ===== src/jse_queue.sv =====
module jse_queue #(
  parameter int unsigned Depth = jse_pkg::QueueDepthDefault
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  jse_pkg::action_t push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             head_valid_o,
  output jse_pkg::action_t head_data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  jse_pkg::action_t mem_q [Depth];
  logic [PtrW-1:0]  wr_q, rd_q;
  logic [CntW-1:0]  cnt_q;

  assign full_o       = (cnt_q == CntW'(Depth));
  assign head_valid_o = (cnt_q != '0);
  assign head_data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= push_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
      if (pop_i) rd_q <= (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
      cnt_q <= cnt_q + CntW'(push_i) - CntW'(pop_i);
    end
  end

endmodule

// ===== src/jse_back.sv =====
module jse_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               head_valid_i,
  input  jse_pkg::action_t   head_data_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output jse_pkg::out_item_t res_item_o
);

  logic [3:0]         step_q;
  logic               out_valid_q;
  jse_pkg::out_item_t out_q;
  jse_pkg::out_item_t nxt;
  logic               load;
  logic               final_step;

  assign out_valid_o = out_valid_q;
  assign res_item_o  = out_q;
  assign load        = head_valid_i && (!out_valid_q || !out_stall_i);
  assign pop_o       = load && final_step;

  always_comb begin
    logic [3:0] tail_len;
    logic [3:0] len;
    logic [3:0] j;
    logic [2:0] di;
    logic [3:0] nib;
    jse_pkg::action_t a;
    a = head_data_i;
    case (a.kind)
      jse_pkg::KIND_RAW:   tail_len = 4'd1;
      jse_pkg::KIND_ESC:   tail_len = 4'd2;
      jse_pkg::KIND_HEX:   tail_len = 4'd2 + {1'b0, a.nd};
      jse_pkg::KIND_CLOSE: tail_len = 4'd1;
      jse_pkg::KIND_ERR:   tail_len = 4'd1;
      default:             tail_len = 4'd0;
    endcase
    len        = {3'b000, a.open_quote} + tail_len;
    final_step = (step_q == len - 4'd1);
    j          = step_q - {3'b000, a.open_quote};
    // hex digits go out most significant first
    di         = 3'({1'b0, a.nd} + 4'd1 - j);
    case (di)
      3'd0:    nib = a.value[3:0];
      3'd1:    nib = a.value[7:4];
      3'd2:    nib = a.value[11:8];
      3'd3:    nib = a.value[15:12];
      3'd4:    nib = a.value[19:16];
      3'd5:    nib = {3'b000, a.value[20]};
      default: nib = 4'h0;
    endcase

    nxt.out_char = jse_pkg::CharQuote;
    nxt.last     = 1'b0;
    nxt.error    = 1'b0;
    if (!(a.open_quote && step_q == 4'd0)) begin
      case (a.kind)
        jse_pkg::KIND_RAW: nxt.out_char = a.chr;
        jse_pkg::KIND_ESC: nxt.out_char = (j == 4'd0) ? jse_pkg::CharBslash : a.chr;
        jse_pkg::KIND_HEX: begin
          if (j == 4'd0) nxt.out_char = jse_pkg::CharBslash;
          else if (j == 4'd1) nxt.out_char = jse_pkg::CharLowerU;
          else nxt.out_char = jse_pkg::hex_char(nib);
        end
        jse_pkg::KIND_CLOSE: begin
          nxt.out_char = jse_pkg::CharQuote;
          nxt.last     = 1'b1;
        end
        jse_pkg::KIND_ERR: begin
          nxt.out_char = jse_pkg::CharNul;
          nxt.last     = 1'b1;
          nxt.error    = 1'b1;
        end
        default: nxt.out_char = jse_pkg::CharNul;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) out_q <= nxt;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      step_q      <= 4'd0;
    end else begin
      if (load) begin
        out_valid_q <= 1'b1;
        step_q      <= final_step ? 4'd0 : step_q + 4'd1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule
